@@ design/nfts_pkg.sv @@
`timescale 1ns / 1ps

package nfts_pkg;

   localparam int TILE_ID_W = 7;
   localparam int CORE_ID_W = 8;
   localparam int STATUS_W  = 2;
   localparam int COST_W    = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COST_W-1:0] COST_UNAVAILABLE = 4'd15;
   localparam logic [COST_W-1:0] COST_MAX_DIST    = 4'd14;

   localparam logic [TILE_ID_W-1:0] HOST_TILE_RESET = 7'd1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_BUSY     = 2'd0,
      STATUS_READY    = 2'd1,
      STATUS_FREE     = 2'd2,
      STATUS_RESERVED = 2'd3
   } tile_state_type;

   // word index taken from paddr[2]
   typedef enum logic {
      CSR_HOST_TILE_ID = 1'b0,
      CSR_UNUSED       = 1'b1
   } csr_index_type;

endpackage

@@ design/nfts_if.sv @@
`timescale 1ns / 1ps

interface nfts_req_if;
   logic                           valid;
   logic                           ready;
   logic [nfts_pkg::TILE_ID_W-1:0] tile_id;
   logic [nfts_pkg::CORE_ID_W-1:0] core_id;
   logic [nfts_pkg::STATUS_W-1:0]  tile_state;
   logic                           last_offer;

   modport source (output valid, tile_id, core_id, tile_state, last_offer, input ready);
   modport sink   (input valid, tile_id, core_id, tile_state, last_offer, output ready);
endinterface

interface nfts_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic [nfts_pkg::TILE_ID_W-1:0] best_tile;
   logic [nfts_pkg::CORE_ID_W-1:0] best_core;
   logic [nfts_pkg::COST_W-1:0]    best_cost;

   modport source (output valid, found, best_tile, best_core, best_cost, input ready);
   modport sink   (input valid, found, best_tile, best_core, best_cost, output ready);
endinterface

@@ design/nearest_free_tile_selector_unit.sv @@
`timescale 1ns / 1ps

// Nearest free tile selector. Offers (tile, core, status, last mark) stream in on req_channel;
// ready and free tiles cost the Manhattan distance, capped at 14, to the host tile set in register 0
// (byte address 0); busy, reserved or off-mesh tiles, and all tiles while the host is off-mesh,
// cost 15. The lowest cost is kept, a tie goes to the later offer, and on the offer marked last
// one word goes out on rsp_channel and the run state clears. One offer is taken every clock
// cycle unless the input is stalled; an offer passes an input register and then the cost and
// compare logic into the result register, so a result word is registered once its last offer
// leaves the input register. Only a last offer meeting an untaken result stalls the input.
module nearest_free_tile_selector_unit #(
   parameter int MESH_COLUMNS = 8,
   parameter int MESH_ROWS    = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   nfts_req_if.sink                         req_channel,
   nfts_rsp_if.source                       rsp_channel,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [nfts_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [nfts_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [nfts_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam int ID_W   = nfts_pkg::TILE_ID_W;
   localparam int CORE_W = nfts_pkg::CORE_ID_W;
   localparam int ST_W   = nfts_pkg::STATUS_W;
   localparam int COST_W = nfts_pkg::COST_W;
   localparam int TAB_DEPTH = 2 ** ID_W;
   localparam int TILES_W = 13;
   localparam logic [TILES_W-1:0] MESH_TILES = TILES_W'(MESH_ROWS * MESH_COLUMNS);

   // row and column of a zero-based tile index
   logic [ID_W-1:0] row_tab [TAB_DEPTH];
   logic [ID_W-1:0] col_tab [TAB_DEPTH];

   for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_tab
      localparam int ROW_V = i / MESH_COLUMNS;
      localparam int COL_V = i % MESH_COLUMNS;
      assign row_tab[i] = ID_W'(ROW_V);
      assign col_tab[i] = ID_W'(COL_V);
   end

   logic [ID_W-1:0]   host_tile_ff, host_tile_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [ID_W-1:0]   s1_tile_ff, s1_tile_in;
   logic [CORE_W-1:0] s1_core_ff, s1_core_in;
   logic [ST_W-1:0]   s1_status_ff, s1_status_in;
   logic              s1_last_ff, s1_last_in;

   logic [COST_W-1:0] lowest_cost_ff, lowest_cost_in;
   logic [ID_W-1:0]   chosen_tile_ff, chosen_tile_in;
   logic [CORE_W-1:0] chosen_core_ff, chosen_core_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_found_ff, out_found_in;
   logic [ID_W-1:0]   out_tile_ff, out_tile_in;
   logic [CORE_W-1:0] out_core_ff, out_core_in;
   logic [COST_W-1:0] out_cost_ff, out_cost_in;

   logic              out_free, s1_go, req_accept, csr_write;
   logic [ID_W-1:0]   t_idx, h_idx, d_row, d_col;
   logic [ID_W:0]     manhattan;
   logic              tile_on_mesh, host_on_mesh, usable;
   logic [COST_W-1:0] cost, new_cost;
   logic [ID_W-1:0]   new_tile;
   logic [CORE_W-1:0] new_core;
   logic              take, run_found;

   assign out_free   = !out_valid_ff || rsp_channel.ready;
   assign s1_go      = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_channel.ready = !s1_valid_ff || s1_go;
   assign req_accept = req_channel.valid && req_channel.ready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == nfts_pkg::CSR_HOST_TILE_ID)
                       ? {{(nfts_pkg::CSR_DATA_W - ID_W){1'b0}}, host_tile_ff}
                       : '0;

   // cost of the registered offer
   always_comb begin
      t_idx = s1_tile_ff - ID_W'(1);
      h_idx = host_tile_ff - ID_W'(1);
      d_row = (row_tab[t_idx] > row_tab[h_idx]) ? row_tab[t_idx] - row_tab[h_idx]
                                                : row_tab[h_idx] - row_tab[t_idx];
      d_col = (col_tab[t_idx] > col_tab[h_idx]) ? col_tab[t_idx] - col_tab[h_idx]
                                                : col_tab[h_idx] - col_tab[t_idx];
      manhattan = {1'b0, d_row} + {1'b0, d_col};
      tile_on_mesh = (s1_tile_ff != '0)
                     && ({{(TILES_W - ID_W){1'b0}}, s1_tile_ff} <= MESH_TILES);
      host_on_mesh = (host_tile_ff != '0)
                     && ({{(TILES_W - ID_W){1'b0}}, host_tile_ff} <= MESH_TILES);
      usable = (s1_status_ff == nfts_pkg::STATUS_READY
                || s1_status_ff == nfts_pkg::STATUS_FREE)
               && tile_on_mesh && host_on_mesh;
      if (!usable) begin
         cost = nfts_pkg::COST_UNAVAILABLE;
      end else if (manhattan > (ID_W + 1)'(nfts_pkg::COST_MAX_DIST)) begin
         cost = nfts_pkg::COST_MAX_DIST;
      end else begin
         cost = COST_W'(manhattan);
      end
      take      = cost <= lowest_cost_ff;
      new_cost  = take ? cost : lowest_cost_ff;
      new_tile  = take ? s1_tile_ff : chosen_tile_ff;
      new_core  = take ? s1_core_ff : chosen_core_ff;
      run_found = new_cost < nfts_pkg::COST_UNAVAILABLE;
   end

   always_comb begin
      host_tile_in = host_tile_ff;
      if (csr_write && csr_paddr[2] == nfts_pkg::CSR_HOST_TILE_ID) begin
         host_tile_in = csr_pwdata[ID_W-1:0];
      end

      s1_valid_in  = s1_valid_ff;
      s1_tile_in   = s1_tile_ff;
      s1_core_in   = s1_core_ff;
      s1_status_in = s1_status_ff;
      s1_last_in   = s1_last_ff;
      if (req_accept) begin
         s1_valid_in  = 1'b1;
         s1_tile_in   = req_channel.tile_id;
         s1_core_in   = req_channel.core_id;
         s1_status_in = req_channel.tile_state;
         s1_last_in   = req_channel.last_offer;
      end else if (s1_go) begin
         s1_valid_in  = 1'b0;
      end

      lowest_cost_in = lowest_cost_ff;
      chosen_tile_in = chosen_tile_ff;
      chosen_core_in = chosen_core_ff;
      out_valid_in   = out_valid_ff && !rsp_channel.ready;
      out_found_in   = out_found_ff;
      out_tile_in    = out_tile_ff;
      out_core_in    = out_core_ff;
      out_cost_in    = out_cost_ff;
      if (s1_go) begin
         if (s1_last_ff) begin
            lowest_cost_in = nfts_pkg::COST_UNAVAILABLE;
            chosen_tile_in = '0;
            chosen_core_in = '0;
            out_valid_in   = 1'b1;
            out_found_in   = run_found;
            out_tile_in    = run_found ? new_tile : '0;
            out_core_in    = run_found ? new_core : '0;
            out_cost_in    = run_found ? new_cost : nfts_pkg::COST_UNAVAILABLE;
         end else begin
            lowest_cost_in = new_cost;
            chosen_tile_in = new_tile;
            chosen_core_in = new_core;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         host_tile_ff   <= nfts_pkg::HOST_TILE_RESET;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         lowest_cost_ff <= nfts_pkg::COST_UNAVAILABLE;
         chosen_tile_ff <= '0;
         chosen_core_ff <= '0;
      end else begin
         host_tile_ff   <= host_tile_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
         lowest_cost_ff <= lowest_cost_in;
         chosen_tile_ff <= chosen_tile_in;
         chosen_core_ff <= chosen_core_in;
      end
      s1_tile_ff   <= s1_tile_in;
      s1_core_ff   <= s1_core_in;
      s1_status_ff <= s1_status_in;
      s1_last_ff   <= s1_last_in;
      out_found_ff <= out_found_in;
      out_tile_ff  <= out_tile_in;
      out_core_ff  <= out_core_in;
      out_cost_ff  <= out_cost_in;
   end

   assign rsp_channel.valid     = out_valid_ff;
   assign rsp_channel.found     = out_found_ff;
   assign rsp_channel.best_tile = out_tile_ff;
   assign rsp_channel.best_core = out_core_ff;
   assign rsp_channel.best_cost = out_cost_ff;

endmodule

@@ design/nfts_checker.sv @@
`timescale 1ns / 1ps

module nfts_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_last_offer,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_found,
   input logic [nfts_pkg::TILE_ID_W-1:0] rsp_best_tile,
   input logic [nfts_pkg::CORE_ID_W-1:0] rsp_best_core,
   input logic [nfts_pkg::COST_W-1:0]    rsp_best_cost
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_best_tile) && $stable(rsp_best_core) && $stable(rsp_best_cost))
      else $error("result word changed while stalled");

   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_best_tile == '0 && rsp_best_core == '0
         && rsp_best_cost == nfts_pkg::COST_UNAVAILABLE)
      else $error("empty result carries a choice");

   a_found_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_best_cost < nfts_pkg::COST_UNAVAILABLE
         && rsp_best_tile != '0)
      else $error("found result with unavailable cost or no tile");

   // a new word needs an accepted last offer, passed through the input register, or a stalled input
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) && !$past(reset) && !$past(reset, 2)
         |-> $past(req_valid && req_ready && req_last_offer, 2)
            || !$past(req_ready))
      else $error("result word without a last offer");

endmodule

bind nearest_free_tile_selector_unit nfts_checker u_nfts_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_channel.valid),
   .req_ready      (req_channel.ready),
   .req_last_offer (req_channel.last_offer),
   .rsp_valid      (rsp_channel.valid),
   .rsp_ready      (rsp_channel.ready),
   .rsp_found      (rsp_channel.found),
   .rsp_best_tile  (rsp_channel.best_tile),
   .rsp_best_core  (rsp_channel.best_core),
   .rsp_best_cost  (rsp_channel.best_cost)
);
